### hw/rtl/ogf_pkg.sv
package ogf_pkg;

   // Global grid geometry.
   localparam int GRID_SIZE      = 512;
   localparam int GRID_BITS      = $clog2(GRID_SIZE);
   localparam int MEM_DEPTH      = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_BITS      = 2 * GRID_BITS;
   localparam int LOCAL_MAX      = 256;

   // Half the grid size, in sixteenths of a cell.
   localparam int HALF_SIXTEENTHS = GRID_SIZE * 8;

   // Occupancy levels.
   localparam int UNKNOWN_LEVEL  = 50;
   localparam int OBSTACLE_LEVEL = 60;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COS_HEADING = 3'd0,
      CSR_SIN_HEADING = 3'd1,
      CSR_POS_X       = 3'd2,
      CSR_POS_Y       = 3'd3,
      CSR_LOCAL_WIDTH = 3'd4,
      CSR_KEEP_WEIGHT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_WRITTEN = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MULT,
      ST_ROTATE,
      ST_ADDRESS,
      ST_BLEND
   } state_type;

   typedef struct packed {
      logic [7:0]        local_col;
      logic [7:0]        local_row;
      logic signed [7:0] cell_value;
   } req_item_type;

   typedef struct packed {
      logic [8:0]        global_x;
      logic [8:0]        global_y;
      logic signed [7:0] blended_value;
      logic [1:0]        status;
      logic              is_obstacle;
   } rsp_item_type;

endpackage

### hw/rtl/ogf_ram.sv
module ogf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/occupancy_grid_fusion_unit.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   ogf_pkg::req_item_type (local cell)
// rsp      out        rsp_valid/rsp_stall   ogf_pkg::rsp_item_type (global cell)
// csr      in         csr_wr_en             csr_index, csr_wr_data (write only)
//
// An item passes through these steps in order: the cycle in which it is accepted
// forms the centered offsets, then ST_MULT does the four heading multiplies,
// ST_ROTATE the rotation sums, ST_ADDRESS builds the grid address and reads the
// grid memory, and ST_BLEND blends, writes back a known in-grid value and loads
// the output register. The next item is accepted only once the block is idle again.
// Only one item is in flight, so the single grid memory port pair never sees
// overlapping accesses to one cell. After reset a clearing pass writes the unknown
// level into all 262144 grid cells, one per cycle, and no item is accepted until it
// ends. A stalled result holds the blend stage, and no next item is accepted
// until the result register is free to take it.
module occupancy_grid_fusion_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ogf_pkg::req_item_type                req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ogf_pkg::rsp_item_type                rsp_item,
   input  logic                                 csr_wr_en,
   input  logic [ogf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ogf_pkg::CSR_DATA_BITS-1:0]    csr_wr_data
);

   // Configuration registers.
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_ff;
   logic signed [17:0] pos_x_ff;
   logic signed [17:0] pos_y_ff;
   logic [8:0]         width_ff;
   logic [8:0]         keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff   <= 16'sd16384;
         sin_ff   <= 16'sd0;
         pos_x_ff <= 18'sd0;
         pos_y_ff <= 18'sd0;
         width_ff <= 9'd256;
         keep_ff  <= 9'd230;
      end else if (csr_wr_en) begin
         unique case (ogf_pkg::csr_index_type'(csr_index))
            ogf_pkg::CSR_COS_HEADING: cos_ff   <= csr_wr_data[15:0];
            ogf_pkg::CSR_SIN_HEADING: sin_ff   <= csr_wr_data[15:0];
            ogf_pkg::CSR_POS_X:       pos_x_ff <= csr_wr_data[17:0];
            ogf_pkg::CSR_POS_Y:       pos_y_ff <= csr_wr_data[17:0];
            ogf_pkg::CSR_LOCAL_WIDTH: width_ff <= csr_wr_data[8:0];
            ogf_pkg::CSR_KEEP_WEIGHT: keep_ff  <= csr_wr_data[8:0];
            default: ;
         endcase
      end
   end

   // Control state.
   ogf_pkg::state_type state_ff, state_in;
   logic [ogf_pkg::ADDR_BITS-1:0] clear_addr_ff, clear_addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   ogf_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // Item payload registers along the steps.
   logic signed [10:0] di_ff, dj_ff;
   logic signed [7:0]  value_ff;
   logic               local_big_ff;
   logic signed [26:0] prod_dc_ff, prod_ds_ff, prod_jc_ff, prod_js_ff;
   logic signed [12:0] rx_ff, ry_ff;
   logic [ogf_pkg::ADDR_BITS-1:0] addr_ff;
   logic [8:0]         gx_ff, gy_ff;
   logic               outside_ff;

   logic accept;
   logic out_free;
   logic load_rsp;

   assign accept    = (state_ff == ogf_pkg::ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ogf_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == ogf_pkg::ST_BLEND) && out_free;

   // Centered offsets in half-cell units: 2i - W and 2j - W.
   logic signed [10:0] di_in, dj_in;
   assign di_in = $signed({2'b00, req_item.local_col, 1'b0}) - $signed({2'b00, width_ff});
   assign dj_in = $signed({2'b00, req_item.local_row, 1'b0}) - $signed({2'b00, width_ff});

   // Heading multiplies.
   logic signed [26:0] prod_dc_in, prod_ds_in, prod_jc_in, prod_js_in;
   assign prod_dc_in = di_ff * cos_ff;
   assign prod_ds_in = di_ff * sin_ff;
   assign prod_jc_in = dj_ff * cos_ff;
   assign prod_js_in = dj_ff * sin_ff;

   // Rotation sums in Q1.14 with one extra halving for the half-cell units,
   // truncated toward zero to whole cells.
   logic signed [27:0] sum_x, sum_y, sh_x, sh_y;
   logic signed [12:0] rx_in, ry_in;
   assign sum_x = 28'(prod_dc_ff) - 28'(prod_js_ff);
   assign sum_y = 28'(prod_ds_ff) + 28'(prod_jc_ff);
   assign sh_x  = sum_x[27] ? ((sum_x + 28'sd32767) >>> 15) : (sum_x >>> 15);
   assign sh_y  = sum_y[27] ? ((sum_y + 28'sd32767) >>> 15) : (sum_y >>> 15);
   assign rx_in = 13'(sh_x);
   assign ry_in = 13'(sh_y);

   // Global position in sixteenths, then truncated toward zero to a cell.
   logic signed [19:0] pos_sum_x, pos_sum_y, pos_sh_x, pos_sh_y;
   logic signed [15:0] gx, gy;
   logic               outside_in;
   assign pos_sum_x = 20'(ogf_pkg::HALF_SIXTEENTHS) + 20'(pos_x_ff)
                      + 20'($signed({rx_ff, 4'b0000}));
   assign pos_sum_y = 20'(ogf_pkg::HALF_SIXTEENTHS) + 20'(pos_y_ff)
                      + 20'($signed({ry_ff, 4'b0000}));
   assign pos_sh_x  = pos_sum_x[19] ? ((pos_sum_x + 20'sd15) >>> 4) : (pos_sum_x >>> 4);
   assign pos_sh_y  = pos_sum_y[19] ? ((pos_sum_y + 20'sd15) >>> 4) : (pos_sum_y >>> 4);
   assign gx        = 16'(pos_sh_x);
   assign gy        = 16'(pos_sh_y);
   assign outside_in = local_big_ff || gx[15] || gy[15] ||
                       (gx >= 16'(ogf_pkg::GRID_SIZE)) || (gy >= 16'(ogf_pkg::GRID_SIZE));

   // Exponential blend of the stored value with the local value.
   logic signed [7:0]  old_value;
   logic [8:0]         keep_sat, keep_comp;
   logic signed [17:0] term_old, term_new;
   logic signed [18:0] blend_sum, blend_sh;
   logic signed [10:0] new_value;
   logic               is_unknown;
   assign keep_sat   = (keep_ff > 9'd256) ? 9'd256 : keep_ff;
   assign keep_comp  = 9'd256 - keep_sat;
   assign term_old   = old_value * $signed({1'b0, keep_sat});
   assign term_new   = value_ff * $signed({1'b0, keep_comp});
   assign blend_sum  = 19'(term_old) + 19'(term_new);
   assign blend_sh   = blend_sum[18] ? ((blend_sum + 19'sd255) >>> 8) : (blend_sum >>> 8);
   assign new_value  = 11'(blend_sh);
   assign is_unknown = (value_ff == 8'(ogf_pkg::UNKNOWN_LEVEL));

   // Grid memory: written by the clearing pass or by the blend write-back.
   logic                          mem_wr_en;
   logic [ogf_pkg::ADDR_BITS-1:0] mem_wr_addr;
   logic [7:0]                    mem_wr_data;
   logic                          mem_rd_en;

   ogf_ram #(
      .WIDTH (8),
      .DEPTH (ogf_pkg::MEM_DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr ({gy[ogf_pkg::GRID_BITS-1:0], gx[ogf_pkg::GRID_BITS-1:0]}),
      .rd_data (old_value)
   );

   // Sequencer: next state, memory controls and the result register load.
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = new_value[7:0];
      mem_rd_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      unique case (state_ff)
         ogf_pkg::ST_CLEAR: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = clear_addr_ff;
            mem_wr_data   = 8'(ogf_pkg::UNKNOWN_LEVEL);
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ogf_pkg::ADDR_BITS'(ogf_pkg::MEM_DEPTH - 1)) begin
               state_in = ogf_pkg::ST_IDLE;
            end
         end
         ogf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ogf_pkg::ST_MULT;
            end
         end
         ogf_pkg::ST_MULT: begin
            state_in = ogf_pkg::ST_ROTATE;
         end
         ogf_pkg::ST_ROTATE: begin
            state_in = ogf_pkg::ST_ADDRESS;
         end
         ogf_pkg::ST_ADDRESS: begin
            mem_rd_en = !outside_in;
            state_in  = ogf_pkg::ST_BLEND;
         end
         ogf_pkg::ST_BLEND: begin
            if (load_rsp) begin
               state_in     = ogf_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (outside_ff) begin
                  rsp_item_in.global_x      = 9'd0;
                  rsp_item_in.global_y      = 9'd0;
                  rsp_item_in.blended_value = 8'sd0;
                  rsp_item_in.status        = ogf_pkg::STATUS_OUTSIDE;
                  rsp_item_in.is_obstacle   = 1'b0;
               end else if (is_unknown) begin
                  rsp_item_in.global_x      = gx_ff;
                  rsp_item_in.global_y      = gy_ff;
                  rsp_item_in.blended_value = old_value;
                  rsp_item_in.status        = ogf_pkg::STATUS_UNKNOWN;
                  rsp_item_in.is_obstacle   = 1'b0;
               end else begin
                  mem_wr_en                 = 1'b1;
                  rsp_item_in.global_x      = gx_ff;
                  rsp_item_in.global_y      = gy_ff;
                  rsp_item_in.blended_value = new_value[7:0];
                  rsp_item_in.status        = ogf_pkg::STATUS_WRITTEN;
                  rsp_item_in.is_obstacle   = (new_value >= 11'(ogf_pkg::OBSTACLE_LEVEL));
               end
            end
         end
         default: begin
            state_in = ogf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ogf_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (accept) begin
         di_ff        <= di_in;
         dj_ff        <= dj_in;
         value_ff     <= req_item.cell_value;
         local_big_ff <= (int'(req_item.local_col) >= ogf_pkg::GRID_SIZE) ||
                         (int'(req_item.local_row) >= ogf_pkg::GRID_SIZE);
      end
      if (state_ff == ogf_pkg::ST_MULT) begin
         prod_dc_ff <= prod_dc_in;
         prod_ds_ff <= prod_ds_in;
         prod_jc_ff <= prod_jc_in;
         prod_js_ff <= prod_js_in;
      end
      if (state_ff == ogf_pkg::ST_ROTATE) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
      if (state_ff == ogf_pkg::ST_ADDRESS) begin
         addr_ff    <= {gy[ogf_pkg::GRID_BITS-1:0], gx[ogf_pkg::GRID_BITS-1:0]};
         gx_ff      <= gx[8:0];
         gy_ff      <= gy[8:0];
         outside_ff <= outside_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
